/* hdl/alrc_pkg.sv */
`timescale 1ns / 1ps

package alrc_pkg;

  localparam int MODE_W     = 2;
  localparam int KIND_W     = 3;
  localparam int ENTRY_W    = 4;
  localparam int BC_W       = 49;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;

  // request modes
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INVAL = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_RGRANT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WGRANT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WB     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FILL   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DFLUSH = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REJ    = 3'd6;

  // register select, taken from the upper address bit (8-byte stride)
  localparam logic REG_ENABLED     = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef struct packed {
    logic            enabled;
    logic [BC_W-1:0] block_count;
  } cfg_t;

endpackage

/* hdl/alrc_cfg_regs.sv */
`timescale 1ns / 1ps

module alrc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [alrc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [alrc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [alrc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output alrc_pkg::cfg_t                     cfg
);
  import alrc_pkg::*;

  logic            enabled_r;
  logic [BC_W-1:0] block_count_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      block_count_r <= '0;
    end else if (wr_en) begin
      case (paddr[APB_ADDR_W-1])
        REG_ENABLED:     enabled_r     <= pwdata[0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_ADDR_W-1])
      REG_ENABLED:     prdata = APB_DATA_W'(enabled_r);
      REG_BLOCK_COUNT: prdata = APB_DATA_W'(block_count_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.enabled     = enabled_r;
  assign cfg.block_count = block_count_r;

endmodule

/* hdl/assoc_lru_writeback_block_cache_unit.sv */
`timescale 1ns / 1ps
// a read or write walks all ENTRIES tags through one comparator (one per cycle),
//   then a decide state, an optional fill state and a grant state; busy is high throughout
// a new request is taken only while busy is low; a rejected request never leaves idle;
//   flush walks every entry, one writeback per cycle at most
// each result is on the out_ ports for one cycle, the cycle after it is formed; no stall
// reset (synchronous, rst_n low) clears valid, dirty and rank state and the registers
module assoc_lru_writeback_block_cache_unit #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [alrc_pkg::MODE_W-1:0]        in_mode,
  input  logic [ADDR_BITS-1:0]               in_lba,
  output logic                               out_valid,
  output logic [alrc_pkg::KIND_W-1:0]        out_kind,
  output logic [alrc_pkg::ENTRY_W-1:0]       out_entry,
  output logic [ADDR_BITS-1:0]               out_block_addr,
  output logic                               out_hit,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [alrc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [alrc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [alrc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import alrc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (ADDR_BITS > BC_W) ? ADDR_BITS : BC_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_FLUSH  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_GRANT  = 3'd5;
  localparam logic [2:0] ST_INVAL  = 3'd6;
  localparam logic [2:0] ST_DFLUSH = 3'd7;

  cfg_t cfg;

  alrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic               free_r, free_nxt;
  logic [CNT_W-1:0]   vcnt_r, vcnt_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;
  logic [IDX_W-1:0]   rank_r   [ENTRIES];
  logic [IDX_W-1:0]   rank_nxt [ENTRIES];
  logic               out_valid_r, out_valid_nxt;

  // payload state
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [ADDR_BITS-1:0] lba_r, lba_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     hit_rank_r, hit_rank_nxt;
  logic                 hit_dirty_r, hit_dirty_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]     min_idx_r, min_idx_nxt;
  logic [IDX_W-1:0]     min_rank_r, min_rank_nxt;
  logic                 min_dirty_r, min_dirty_nxt;
  logic [ADDR_BITS-1:0] min_tag_r, min_tag_nxt;
  logic [IDX_W-1:0]     vic_idx_r, vic_idx_nxt;
  logic                 vic_valid_r, vic_valid_nxt;
  logic [IDX_W-1:0]     vic_rank_r, vic_rank_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [ENTRY_W-1:0]   out_entry_r, out_entry_nxt;
  logic [ADDR_BITS-1:0] out_addr_r, out_addr_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 out_last_r, out_last_nxt;

  // tag store
  logic [ADDR_BITS-1:0] tag_mem [ENTRIES];
  logic [ADDR_BITS-1:0] tag_q_r;
  logic [IDX_W-1:0]     tag_raddr;
  logic                 tag_we;

  logic                 accept;
  logic                 scan_last;
  logic                 cur_valid, cur_dirty, tag_eq;
  logic [IDX_W-1:0]     cur_rank;
  logic                 out_of_range;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign scan_last = (idx_r == LAST_IDX);
  assign cur_valid = valid_r[idx_r];
  assign cur_dirty = dirty_r[idx_r];
  assign cur_rank  = rank_r[idx_r];
  // the one tag comparator, shared by every step of the scan
  assign tag_eq    = (tag_q_r == lba_r);
  assign out_of_range = (CMP_W'(in_lba) >= CMP_W'(cfg.block_count));

  // read address runs one ahead of the scan index; idle primes entry 0
  always_comb begin
    if ((state_r == ST_SCAN || state_r == ST_FLUSH) && !scan_last) begin
      tag_raddr = idx_r + 1'b1;
    end else begin
      tag_raddr = '0;
    end
  end

  assign tag_we = (state_r == ST_GRANT) && !found_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[vic_idx_r] <= lba_r;
    end
    tag_q_r <= tag_mem[tag_raddr];
  end

  always_comb begin
    logic                 emit;
    logic [KIND_W-1:0]    e_kind;
    logic [IDX_W-1:0]     e_idx;
    logic [ADDR_BITS-1:0] e_addr;
    logic                 e_hit;
    logic                 e_last;
    logic                 unrank;

    state_nxt     = state_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    vcnt_nxt      = vcnt_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    rank_nxt      = rank_r;
    mode_nxt      = mode_r;
    lba_nxt       = lba_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_dirty_nxt = hit_dirty_r;
    free_idx_nxt  = free_idx_r;
    min_idx_nxt   = min_idx_r;
    min_rank_nxt  = min_rank_r;
    min_dirty_nxt = min_dirty_r;
    min_tag_nxt   = min_tag_r;
    vic_idx_nxt   = vic_idx_r;
    vic_valid_nxt = vic_valid_r;
    vic_rank_nxt  = vic_rank_r;

    emit   = 1'b0;
    e_kind = KIND_DONE;
    e_idx  = '0;
    e_addr = lba_r;
    e_hit  = 1'b0;
    e_last = 1'b0;
    unrank = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_mode;
          lba_nxt   = in_lba;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          vcnt_nxt  = '0;
          if (!cfg.enabled ||
              ((in_mode == MODE_READ || in_mode == MODE_WRITE) && out_of_range)) begin
            emit   = 1'b1;
            e_kind = KIND_REJ;
            e_addr = in_lba;
            e_last = 1'b1;
          end else if (in_mode == MODE_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (cur_valid && tag_eq && !found_r) begin
          found_nxt     = 1'b1;
          hit_idx_nxt   = idx_r;
          hit_rank_nxt  = cur_rank;
          hit_dirty_nxt = cur_dirty;
        end
        if (!cur_valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        // lowest rank, first index on ties; only used when every entry is valid
        if (idx_r == '0 || cur_rank < min_rank_r) begin
          min_idx_nxt   = idx_r;
          min_rank_nxt  = cur_rank;
          min_dirty_nxt = cur_dirty;
          min_tag_nxt   = tag_q_r;
        end
        vcnt_nxt = vcnt_r + CNT_W'(cur_valid);
        if (scan_last) begin
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_FLUSH: begin
        if (cur_valid && cur_dirty) begin
          emit   = 1'b1;
          e_kind = KIND_WB;
          e_idx  = idx_r;
          e_addr = tag_q_r;
          dirty_nxt[idx_r] = 1'b0;
        end
        if (scan_last) begin
          state_nxt = ST_DFLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_DFLUSH: begin
        emit      = 1'b1;
        e_kind    = KIND_DFLUSH;
        e_addr    = '0;
        e_last    = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_DECIDE: begin
        if (mode_r == MODE_INVAL) begin
          vic_idx_nxt  = hit_idx_r;
          vic_rank_nxt = hit_rank_r;
          if (!found_r) begin
            emit      = 1'b1;
            e_kind    = KIND_DONE;
            e_last    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            // a hit tag equals the request address
            if (hit_dirty_r) begin
              emit   = 1'b1;
              e_kind = KIND_WB;
              e_idx  = hit_idx_r;
            end
            state_nxt = ST_INVAL;
          end
        end else if (found_r) begin
          vic_idx_nxt   = hit_idx_r;
          vic_valid_nxt = 1'b1;
          vic_rank_nxt  = hit_rank_r;
          state_nxt     = ST_GRANT;
        end else begin
          if (free_r) begin
            vic_idx_nxt   = free_idx_r;
            vic_valid_nxt = 1'b0;
            vic_rank_nxt  = '0;
          end else begin
            vic_idx_nxt   = min_idx_r;
            vic_valid_nxt = 1'b1;
            vic_rank_nxt  = min_rank_r;
          end
          if (!free_r && min_dirty_r) begin
            emit      = 1'b1;
            e_kind    = KIND_WB;
            e_idx     = min_idx_r;
            e_addr    = min_tag_r;
            state_nxt = (mode_r == MODE_READ) ? ST_FILL : ST_GRANT;
          end else if (mode_r == MODE_READ) begin
            emit      = 1'b1;
            e_kind    = KIND_FILL;
            e_idx     = free_r ? free_idx_r : min_idx_r;
            state_nxt = ST_GRANT;
          end else begin
            state_nxt = ST_GRANT;
          end
        end
      end

      ST_FILL: begin
        emit      = 1'b1;
        e_kind    = KIND_FILL;
        e_idx     = vic_idx_r;
        state_nxt = ST_GRANT;
      end

      ST_GRANT: begin
        unrank = vic_valid_r;
        valid_nxt[vic_idx_r] = 1'b1;
        if (mode_r == MODE_WRITE) begin
          dirty_nxt[vic_idx_r] = 1'b1;
        end else if (!found_r) begin
          dirty_nxt[vic_idx_r] = 1'b0;
        end
        emit      = 1'b1;
        e_kind    = (mode_r == MODE_READ) ? KIND_RGRANT : KIND_WGRANT;
        e_idx     = vic_idx_r;
        e_hit     = found_r;
        e_last    = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_INVAL: begin
        unrank = 1'b1;
        valid_nxt[vic_idx_r] = 1'b0;
        dirty_nxt[vic_idx_r] = 1'b0;
        emit      = 1'b1;
        e_kind    = KIND_DONE;
        e_idx     = vic_idx_r;
        e_hit     = 1'b1;
        e_last    = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // younger valid entries step down one rank; a granted entry goes to the top, an invalidated one to rank 0
    for (int i = 0; i < ENTRIES; i++) begin
      if (IDX_W'(i) == vic_idx_r) begin
        if (state_r == ST_GRANT) begin
          rank_nxt[i] = vic_valid_r ? IDX_W'(vcnt_r - 1'b1) : IDX_W'(vcnt_r);
        end else if (state_r == ST_INVAL) begin
          rank_nxt[i] = '0;
        end
      end else if (unrank && valid_r[i] && rank_r[i] > vic_rank_r) begin
        rank_nxt[i] = rank_r[i] - 1'b1;
      end
    end

    out_valid_nxt = emit;
    out_kind_nxt  = emit ? e_kind : out_kind_r;
    out_entry_nxt = emit ? ENTRY_W'(e_idx) : out_entry_r;
    out_addr_nxt  = emit ? e_addr : out_addr_r;
    out_hit_nxt   = emit ? e_hit : out_hit_r;
    out_last_nxt  = emit ? e_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      vcnt_r      <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      vcnt_r      <= vcnt_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      rank_r      <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    lba_r       <= lba_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_dirty_r <= hit_dirty_nxt;
    free_idx_r  <= free_idx_nxt;
    min_idx_r   <= min_idx_nxt;
    min_rank_r  <= min_rank_nxt;
    min_dirty_r <= min_dirty_nxt;
    min_tag_r   <= min_tag_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_valid_r <= vic_valid_nxt;
    vic_rank_r  <= vic_rank_nxt;
    out_kind_r  <= out_kind_nxt;
    out_entry_r <= out_entry_nxt;
    out_addr_r  <= out_addr_nxt;
    out_hit_r   <= out_hit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_entry      = out_entry_r;
  assign out_block_addr = out_addr_r;
  assign out_hit        = out_hit_r;
  assign out_last       = out_last_r;

  // a dirty entry is always a valid one
  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (dirty_r & ~valid_r) == '0)
    else $error("dirty bit set on an invalid entry");

  // the last result of an item leaves the engine idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> !busy)
    else $error("engine still busy after the last result");

  // grants, device flush and rejects always close the item
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_RGRANT || out_kind_r == KIND_WGRANT ||
                    out_kind_r == KIND_DFLUSH || out_kind_r == KIND_REJ) |-> out_last_r)
    else $error("closing result kind without last");

  // only grants and invalidate completion report a hit
  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |->
      (out_kind_r == KIND_RGRANT || out_kind_r == KIND_WGRANT || out_kind_r == KIND_DONE))
    else $error("hit flagged on a device command");

endmodule
